>>> sv/ppas_pkg.sv
// Shared types, constants and fixed-point helpers for the particle pool.
// Used by the slot RAM, the top level
// and the checker.
package ppas_pkg;

  localparam int SLOTS_DEF = 32;
  localparam int SLOT_FW   = 5;

  // 1.0 in unsigned Q1.15, and 0.1 as 6554 / 65536
  localparam logic [15:0]        ONE_Q15   = 16'h8000;
  localparam logic signed [16:0] TENTH_Q16 = 17'sd6554;

  typedef enum logic [0:0] {
    CMD_SPAWN = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    KIND_SPAWN = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SMX,
    ST_SMY,
    ST_SWR,
    ST_TDROP,
    ST_TADR,
    ST_TRD,
    ST_TLD,
    ST_TMY,
    ST_TWR
  } state_t;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MS_DT_TENTH,
    MS_VX_TENTH,
    MS_VY_TENTH,
    MS_VX_DT,
    MS_VY_DT
  } mul_sel_t;

  // one slot of the pool
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [7:0]         shade;
    logic [15:0]        alpha;
    logic [15:0]        life;
  } slot_t;

  // captured input item
  typedef struct packed {
    logic               cmd;
    logic [15:0]        dt;
    logic signed [15:0] obj_pos_x;
    logic signed [15:0] obj_pos_y;
    logic signed [15:0] obj_vel_x;
    logic signed [15:0] obj_vel_y;
    logic signed [7:0]  spawn_offset;
    logic [7:0]         spawn_shade;
  } item_t;

  // result item held in the output register
  typedef struct packed {
    logic                kind;
    logic [SLOT_FW-1:0]  slot;
    logic                alive;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;
    logic [7:0]          shade;
    logic [15:0]         alpha;
    logic [15:0]         life;
    logic                last;
  } res_t;

  // sign extension of a 16-bit value to the working width
  function automatic logic signed [34:0] sx35(input logic [15:0] v);
    sx35 = {{19{v[15]}}, v};
  endfunction

  // round half up of p / 2^16
  function automatic logic signed [34:0] rnd16(input logic signed [33:0] p);
    logic signed [34:0] t;
    t = {p[33], p} + 35'sd32768;
    rnd16 = t >>> 16;
  endfunction

  // round half up of p / 2^15
  function automatic logic signed [34:0] rnd15(input logic signed [33:0] p);
    logic signed [34:0] t;
    t = {p[33], p} + 35'sd16384;
    rnd15 = t >>> 15;
  endfunction

  // clamp to the signed 16-bit range
  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    if (v > 35'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -35'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

>>> sv/ppas_if.sv
// Valid/ready channel interfaces of the particle pool: command input and result output.
// Depends on nothing but plain logic types.
interface ppas_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [15:0]        dt;
  logic signed [15:0] obj_pos_x;
  logic signed [15:0] obj_pos_y;
  logic signed [15:0] obj_vel_x;
  logic signed [15:0] obj_vel_y;
  logic signed [7:0]  spawn_offset;
  logic [7:0]         spawn_shade;

  modport source (
    output valid, cmd, dt, obj_pos_x, obj_pos_y, obj_vel_x, obj_vel_y,
           spawn_offset, spawn_shade,
    input  ready
  );
  modport sink (
    input  valid, cmd, dt, obj_pos_x, obj_pos_y, obj_vel_x, obj_vel_y,
           spawn_offset, spawn_shade,
    output ready
  );
endinterface

interface ppas_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [4:0]         slot;
  logic               alive;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]         shade;
  logic [15:0]        alpha;
  logic [15:0]        life;
  logic               last;

  modport source (
    output valid, kind, slot, alive, pos_x, pos_y, shade, alpha, life, last,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, alive, pos_x, pos_y, shade, alpha, life, last,
    output ready
  );
endinterface

>>> sv/particle_pool_age_and_spawn.sv
// Particle pool with next-fit spawn and fixed-point aging, top level.
// Depends on ppas_pkg, ppas_if, ppas_mul and ppas_slot_ram.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+------------------------------------------
//  in_ch     | in  | valid/ready  | cmd, dt, obj_pos/vel x y, offset, shade
//  out_ch    | out | valid/ready  | kind, slot, alive, pos x y, shade,
//            |     |              | alpha, life, last
//
// Spawn: accept, a next-fit scan of one to SLOTS slots, then SMX, SMY, SWR.
// Tick: TDROP and TADR, then per slot TRD, TLD, TMY and TWR: RAM read, two
// passes through the one shared multiplier (x and y move), then write-back.
// in_ch.ready is high only while idle; a result waiting in the output
// register stalls the write-back step until out_ch takes it.
// Reset is synchronous; per-slot valid bits make every slot read as zero
// at once, so there is no clearing pass.
module particle_pool_age_and_spawn #(
  parameter int SLOTS = ppas_pkg::SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ppas_in_if.sink   in_ch,
  ppas_out_if.source out_ch
);

  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SXW = (SIW > ppas_pkg::SLOT_FW) ? SIW : ppas_pkg::SLOT_FW;

  ppas_pkg::state_t   state_r, state_nxt;
  ppas_pkg::item_t    item_r;
  ppas_pkg::slot_t    ent_r;
  ppas_pkg::slot_t    ld_ent;
  ppas_pkg::slot_t    rdata;
  ppas_pkg::slot_t    wr_ent;
  ppas_pkg::res_t     res_r, res_nxt;
  ppas_pkg::mul_sel_t mul_sel;

  logic [SIW-1:0]     idx_r;
  logic [SIW-1:0]     idx_inc;
  logic [SIW-1:0]     scan_cnt_r;
  logic [SIW-1:0]     ptr_r;
  logic [SXW-1:0]     slot_ext;
  logic [SLOTS-1:0]   alive_r;
  logic               live_r;
  logic [15:0]        adrop_r;
  logic               out_valid_r;

  logic               in_ready;
  logic               advance;
  logic               wr_en;
  logic               mul_en;
  logic               idx_last;
  logic               scan_last;
  logic               is_spawn;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] prod;
  logic signed [34:0] prod_r16;
  logic signed [34:0] prod_r15;
  logic [15:0]        life_new;

  assign advance   = !out_valid_r || out_ch.ready;
  assign idx_last  = (idx_r == SIW'(SLOTS - 1));
  assign scan_last = (scan_cnt_r == SIW'(SLOTS - 1));
  assign idx_inc   = idx_last ? '0 : idx_r + SIW'(1);
  assign is_spawn  = (state_r == ppas_pkg::ST_SWR);
  assign prod_r16  = ppas_pkg::rnd16(prod);
  assign prod_r15  = ppas_pkg::rnd15(prod);
  assign life_new  = (rdata.life > item_r.dt) ? rdata.life - item_r.dt : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppas_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.cmd == ppas_pkg::CMD_TICK) ? ppas_pkg::ST_TDROP
                                                        : ppas_pkg::ST_SCAN;
        end
      end
      ppas_pkg::ST_SCAN: begin
        if (!alive_r[idx_r] || scan_last) begin
          state_nxt = ppas_pkg::ST_SMX;
        end
      end
      ppas_pkg::ST_SMX:   state_nxt = ppas_pkg::ST_SMY;
      ppas_pkg::ST_SMY:   state_nxt = ppas_pkg::ST_SWR;
      ppas_pkg::ST_SWR: begin
        if (advance) begin
          state_nxt = ppas_pkg::ST_IDLE;
        end
      end
      ppas_pkg::ST_TDROP: state_nxt = ppas_pkg::ST_TADR;
      ppas_pkg::ST_TADR:  state_nxt = ppas_pkg::ST_TRD;
      ppas_pkg::ST_TRD:   state_nxt = ppas_pkg::ST_TLD;
      ppas_pkg::ST_TLD:   state_nxt = ppas_pkg::ST_TMY;
      ppas_pkg::ST_TMY:   state_nxt = ppas_pkg::ST_TWR;
      ppas_pkg::ST_TWR: begin
        if (advance) begin
          state_nxt = idx_last ? ppas_pkg::ST_IDLE : ppas_pkg::ST_TRD;
        end
      end
      default: state_nxt = ppas_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    mul_en   = 1'b0;
    mul_sel  = ppas_pkg::MS_DT_TENTH;
    wr_en    = 1'b0;
    unique case (state_r)
      ppas_pkg::ST_IDLE:  in_ready = 1'b1;
      ppas_pkg::ST_SMX: begin
        mul_en  = 1'b1;
        mul_sel = ppas_pkg::MS_VX_TENTH;
      end
      ppas_pkg::ST_SMY: begin
        mul_en  = 1'b1;
        mul_sel = ppas_pkg::MS_VY_TENTH;
      end
      ppas_pkg::ST_TDROP: begin
        mul_en  = 1'b1;
        mul_sel = ppas_pkg::MS_DT_TENTH;
      end
      ppas_pkg::ST_TLD: begin
        mul_en  = 1'b1;
        mul_sel = ppas_pkg::MS_VX_DT;
      end
      ppas_pkg::ST_TMY: begin
        mul_en  = 1'b1;
        mul_sel = ppas_pkg::MS_VY_DT;
      end
      ppas_pkg::ST_SWR,
      ppas_pkg::ST_TWR:   wr_en = advance;
      default: ;
    endcase
  end

  // operand mux of the shared multiplier
  always_comb begin
    unique case (mul_sel)
      ppas_pkg::MS_DT_TENTH: begin
        mul_a = {1'b0, item_r.dt};
        mul_b = ppas_pkg::TENTH_Q16;
      end
      ppas_pkg::MS_VX_TENTH: begin
        mul_a = {item_r.obj_vel_x[15], item_r.obj_vel_x};
        mul_b = ppas_pkg::TENTH_Q16;
      end
      ppas_pkg::MS_VY_TENTH: begin
        mul_a = {item_r.obj_vel_y[15], item_r.obj_vel_y};
        mul_b = ppas_pkg::TENTH_Q16;
      end
      ppas_pkg::MS_VX_DT: begin
        mul_a = {rdata.vel_x[15], rdata.vel_x};
        mul_b = {1'b0, item_r.dt};
      end
      ppas_pkg::MS_VY_DT: begin
        mul_a = {ent_r.vel_y[15], ent_r.vel_y};
        mul_b = {1'b0, item_r.dt};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ppas_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ppas_slot_ram #(
    .DEPTH (SLOTS),
    .AW    (SIW)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (wr_en),
    .waddr (idx_r),
    .wdata (wr_ent),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // slot as read back, with its life already aged
  always_comb begin
    ld_ent      = rdata;
    ld_ent.life = life_new;
  end

  // entry written back: fresh spawn or aged tick slot
  always_comb begin
    wr_ent = ent_r;
    if (is_spawn) begin
      wr_ent.pos_x = ppas_pkg::sat16(ppas_pkg::sx35(item_r.obj_pos_x) +
                       ppas_pkg::sx35({{8{item_r.spawn_offset[7]}}, item_r.spawn_offset}));
      wr_ent.pos_y = ppas_pkg::sat16(ppas_pkg::sx35(item_r.obj_pos_y) +
                       ppas_pkg::sx35({{8{item_r.spawn_offset[7]}}, item_r.spawn_offset}));
      wr_ent.vel_y = ppas_pkg::sat16(prod_r16);
      wr_ent.shade = item_r.spawn_shade;
      wr_ent.alpha = ppas_pkg::ONE_Q15;
      wr_ent.life  = ppas_pkg::ONE_Q15;
    end else if (live_r) begin
      wr_ent.pos_y = ppas_pkg::sat16(ppas_pkg::sx35(ent_r.pos_y) - prod_r15);
      wr_ent.alpha = (ent_r.alpha > adrop_r) ? ent_r.alpha - adrop_r : '0;
    end
  end

  // result item
  assign slot_ext = SXW'(idx_r);
  always_comb begin
    res_nxt.kind  = is_spawn ? ppas_pkg::KIND_SPAWN : ppas_pkg::KIND_TICK;
    res_nxt.slot  = slot_ext[ppas_pkg::SLOT_FW-1:0];
    res_nxt.alive = (wr_ent.life != '0);
    res_nxt.pos_x = wr_ent.pos_x;
    res_nxt.pos_y = wr_ent.pos_y;
    res_nxt.shade = wr_ent.shade;
    res_nxt.alpha = wr_ent.alpha;
    res_nxt.life  = wr_ent.life;
    res_nxt.last  = is_spawn || idx_last;
  end

  // sequencer state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppas_pkg::ST_IDLE;
      idx_r       <= '0;
      scan_cnt_r  <= '0;
      ptr_r       <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        out_valid_r <= 1'b1;
        res_r       <= res_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ppas_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            item_r     <= {in_ch.cmd, in_ch.dt, in_ch.obj_pos_x, in_ch.obj_pos_y,
                           in_ch.obj_vel_x, in_ch.obj_vel_y, in_ch.spawn_offset,
                           in_ch.spawn_shade};
            idx_r      <= (in_ch.cmd == ppas_pkg::CMD_TICK) ? '0 : ptr_r;
            scan_cnt_r <= '0;
          end
        end
        // next-fit scan, one slot a cycle; full pool falls back to slot 0
        ppas_pkg::ST_SCAN: begin
          if (alive_r[idx_r]) begin
            if (scan_last) begin
              idx_r <= '0;
            end else begin
              idx_r      <= idx_inc;
              scan_cnt_r <= scan_cnt_r + SIW'(1);
            end
          end
        end
        ppas_pkg::ST_SMY: ent_r.vel_x <= ppas_pkg::sat16(prod_r16);
        ppas_pkg::ST_SWR: begin
          if (wr_en) begin
            alive_r[idx_r] <= 1'b1;
            ptr_r          <= idx_r;
          end
        end
        ppas_pkg::ST_TADR: adrop_r <= prod_r16[15:0];
        // age life and keep the slot for the move steps
        ppas_pkg::ST_TLD: begin
          ent_r          <= ld_ent;
          live_r         <= (life_new != '0);
          alive_r[idx_r] <= (life_new != '0);
        end
        ppas_pkg::ST_TMY: begin
          if (live_r) begin
            ent_r.pos_x <= ppas_pkg::sat16(ppas_pkg::sx35(ent_r.pos_x) - prod_r15);
          end
        end
        ppas_pkg::ST_TWR: begin
          if (wr_en) begin
            idx_r <= idx_inc;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = res_r.kind;
  assign out_ch.slot  = res_r.slot;
  assign out_ch.alive = res_r.alive;
  assign out_ch.pos_x = res_r.pos_x;
  assign out_ch.pos_y = res_r.pos_y;
  assign out_ch.shade = res_r.shade;
  assign out_ch.alpha = res_r.alpha;
  assign out_ch.life  = res_r.life;
  assign out_ch.last  = res_r.last;

endmodule

>>> sv/ppas_mul.sv
// Shared 17x17 signed multiplier with a registered product.
// Standalone; the sequencer in the top level picks its operands.
module ppas_mul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] a,
  input  logic signed [16:0] b,
  output logic signed [33:0] p
);

  logic signed [33:0] p_r;

  // product holds while not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

>>> sv/ppas_slot_ram.sv
// Slot store: one write and one registered read port, with per-entry valid
// bits so unwritten slots read as zero right after reset. Uses ppas_pkg::slot_t.
module ppas_slot_ram #(
  parameter int DEPTH = ppas_pkg::SLOTS_DEF,
  parameter int AW    = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  ppas_pkg::slot_t      wdata,
  input  logic [AW-1:0]        raddr,
  output ppas_pkg::slot_t      rdata
);

  ppas_pkg::slot_t mem_r [DEPTH];
  ppas_pkg::slot_t rd_r;
  logic [DEPTH-1:0] valid_r;
  logic             rvld_r;

  // storage array
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  // written-entry flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvld_r <= valid_r[raddr];
    end
  end

  assign rdata = rvld_r ? rd_r : '0;

endmodule

>>> sv/ppas_checker.sv
// Port-level checks for the particle pool, bound to the top level.
// Depends on ppas_pkg for the result kinds and the Q1.15 one.
module ppas_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [4:0]  out_slot,
  input logic        out_alive,
  input logic [15:0] out_alpha,
  input logic [15:0] out_life,
  input logic        out_last
);

  // a stalled result stays valid and keeps its slot and life
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_life))
    else $error("result changed while stalled");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // a spawn acknowledgement shows a fresh, live, single result
  a_spawn_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ppas_pkg::KIND_SPAWN |->
      out_alive && out_last && out_life == ppas_pkg::ONE_Q15 &&
      out_alpha == ppas_pkg::ONE_Q15)
    else $error("spawn result not a fresh particle");

  // alive flag agrees with remaining life
  a_alive_life: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alive == (out_life != 16'd0))
    else $error("alive flag disagrees with life");

  // life and alpha never exceed one
  a_q15_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_alpha <= ppas_pkg::ONE_Q15 && out_life <= ppas_pkg::ONE_Q15)
    else $error("life or alpha above one");

endmodule

bind particle_pool_age_and_spawn ppas_port_checks u_ppas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_slot  (out_ch.slot),
  .out_alive (out_ch.alive),
  .out_alpha (out_ch.alpha),
  .out_life  (out_ch.life),
  .out_last  (out_ch.last)
);
